/* sv/assert_macros.svh */
// Assertion helpers used by the transform matrix stack unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that an expression is never true on a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* sv/tms_pkg.sv */
// ----------------------------------------------------------------------------
// Transform matrix stack package
// Shared types, command codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package tms_pkg;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_LOAD   = 4'd1,
    ST_SINE   = 4'd2,
    ST_ROT    = 4'd3,
    ST_MAC    = 4'd4,
    ST_COPY   = 4'd5,
    ST_FILL   = 4'd6,
    ST_EMIT   = 4'd7,
    ST_FINISH = 4'd8
  } state_t;

  localparam logic [2:0] OP_IDENTITY  = 3'd0;
  localparam logic [2:0] OP_PUSH      = 3'd1;
  localparam logic [2:0] OP_POP       = 3'd2;
  localparam logic [2:0] OP_TRANSLATE = 3'd3;
  localparam logic [2:0] OP_SCALE     = 3'd4;
  localparam logic [2:0] OP_ROTATE    = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Operand selects of the rotation setup program; 0 to 15 address the matrix.
  localparam logic [4:0] SEL_X   = 5'd16;
  localparam logic [4:0] SEL_Y   = 5'd17;
  localparam logic [4:0] SEL_Z   = 5'd18;
  localparam logic [4:0] SEL_S   = 5'd19;
  localparam logic [4:0] SEL_C   = 5'd20;
  localparam logic [4:0] SEL_CC  = 5'd21;
  localparam logic [4:0] SEL_TMP = 5'd22;

  localparam logic [4:0] ROT_LAST_STEP = 5'd23;

  typedef enum logic {
    STEP_MUL = 1'b0,
    STEP_ADD = 1'b1
  } step_op_t;

  typedef struct packed {
    step_op_t   op;
    logic [4:0] a;
    logic [4:0] b;
    logic       neg;
    logic [4:0] dst;
    logic       dup_en;
    logic [3:0] dup;
  } rot_step_t;

  function automatic rot_step_t mk(input step_op_t op, input logic [4:0] a,
                                   input logic [4:0] b, input logic neg,
                                   input logic [4:0] dst, input logic dup_en,
                                   input logic [3:0] dup);
    rot_step_t s;
    s.op = op; s.a = a; s.b = b; s.neg = neg;
    s.dst = dst; s.dup_en = dup_en; s.dup = dup;
    return s;
  endfunction

  // A multiply step writes round(a*b); an add step writes sat(dst +/- b).
  function automatic rot_step_t rot_step(input logic [4:0] n);
    rot_step_t s;
    unique case (n)
      5'd0:  s = mk(STEP_MUL, SEL_X,   SEL_X,  1'b0, SEL_TMP, 1'b0, 4'd0);
      5'd1:  s = mk(STEP_MUL, SEL_TMP, SEL_CC, 1'b0, 5'd0,    1'b0, 4'd0);
      5'd2:  s = mk(STEP_ADD, 5'd0,    SEL_C,  1'b0, 5'd0,    1'b0, 4'd0);
      5'd3:  s = mk(STEP_MUL, SEL_X,   SEL_Y,  1'b0, SEL_TMP, 1'b0, 4'd0);
      5'd4:  s = mk(STEP_MUL, SEL_TMP, SEL_CC, 1'b0, 5'd1,    1'b1, 4'd4);
      5'd5:  s = mk(STEP_MUL, SEL_Z,   SEL_S,  1'b0, SEL_TMP, 1'b0, 4'd0);
      5'd6:  s = mk(STEP_ADD, 5'd0,    SEL_TMP, 1'b1, 5'd1,   1'b0, 4'd0);
      5'd7:  s = mk(STEP_ADD, 5'd0,    SEL_TMP, 1'b0, 5'd4,   1'b0, 4'd0);
      5'd8:  s = mk(STEP_MUL, SEL_X,   SEL_Z,  1'b0, SEL_TMP, 1'b0, 4'd0);
      5'd9:  s = mk(STEP_MUL, SEL_TMP, SEL_CC, 1'b0, 5'd2,    1'b1, 4'd8);
      5'd10: s = mk(STEP_MUL, SEL_Y,   SEL_S,  1'b0, SEL_TMP, 1'b0, 4'd0);
      5'd11: s = mk(STEP_ADD, 5'd0,    SEL_TMP, 1'b0, 5'd2,   1'b0, 4'd0);
      5'd12: s = mk(STEP_ADD, 5'd0,    SEL_TMP, 1'b1, 5'd8,   1'b0, 4'd0);
      5'd13: s = mk(STEP_MUL, SEL_Y,   SEL_Y,  1'b0, SEL_TMP, 1'b0, 4'd0);
      5'd14: s = mk(STEP_MUL, SEL_TMP, SEL_CC, 1'b0, 5'd5,    1'b0, 4'd0);
      5'd15: s = mk(STEP_ADD, 5'd0,    SEL_C,  1'b0, 5'd5,    1'b0, 4'd0);
      5'd16: s = mk(STEP_MUL, SEL_Y,   SEL_Z,  1'b0, SEL_TMP, 1'b0, 4'd0);
      5'd17: s = mk(STEP_MUL, SEL_TMP, SEL_CC, 1'b0, 5'd6,    1'b1, 4'd9);
      5'd18: s = mk(STEP_MUL, SEL_X,   SEL_S,  1'b0, SEL_TMP, 1'b0, 4'd0);
      5'd19: s = mk(STEP_ADD, 5'd0,    SEL_TMP, 1'b1, 5'd6,   1'b0, 4'd0);
      5'd20: s = mk(STEP_ADD, 5'd0,    SEL_TMP, 1'b0, 5'd9,   1'b0, 4'd0);
      5'd21: s = mk(STEP_MUL, SEL_Z,   SEL_Z,  1'b0, SEL_TMP, 1'b0, 4'd0);
      5'd22: s = mk(STEP_MUL, SEL_TMP, SEL_CC, 1'b0, 5'd10,   1'b0, 4'd0);
      default: s = mk(STEP_ADD, 5'd0,  SEL_C,  1'b0, 5'd10,   1'b0, 4'd0);
    endcase
    return s;
  endfunction

  function automatic logic is_diag(input logic [3:0] k);
    return (k == 4'd0) || (k == 4'd5) || (k == 4'd10) || (k == 4'd15);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Round to Q15.16 (add half, floor) and saturate.
  function automatic logic signed [31:0] round_sat(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = (v + 66'sd32768) >>> 16;
    return sat32(r);
  endfunction

  // Sine of a Q2.30 angle by a truncating Taylor series, rounded to Q16.
  function automatic logic [16:0] sine_from_x(input logic [63:0] x);
    logic [63:0] t;
    logic signed [65:0] sum;
    t = x;
    sum = $signed({2'b00, x});
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd6;
    sum = sum - $signed({2'b00, t});
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd20;
    sum = sum + $signed({2'b00, t});
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd42;
    sum = sum - $signed({2'b00, t});
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd72;
    sum = sum + $signed({2'b00, t});
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd110;
    sum = sum - $signed({2'b00, t});
    t = (t * x) >> 30; t = (t * x) >> 30; t = t / 64'd156;
    sum = sum + $signed({2'b00, t});
    if (sum < 0) sum = '0;
    sum = (sum + 66'sd8192) >>> 14;
    if (sum > 66'sd65536) sum = 66'sd65536;
    return sum[16:0];
  endfunction

endpackage

/* sv/tms_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tms_sine_rom.sv */
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Entry i holds the sine of i/ENTRIES of a quarter turn in Q16, read registered.
// ----------------------------------------------------------------------------
module tms_sine_rom #(
  parameter int ENTRIES = 256
) (
  input  logic                         clk,
  input  logic [$clog2(ENTRIES+1)-1:0] addr,
  output logic [16:0]                  data
);

  logic [16:0] tab [ENTRIES+1];

  for (genvar g = 0; g <= ENTRIES; g++) begin : g_tab
    localparam logic [63:0] XQ = (64'(g) * tms_pkg::HALF_PI_Q30) / ENTRIES;
    if (g == 0) begin : g_zero
      assign tab[g] = 17'd0;
    end else if (g == ENTRIES) begin : g_one
      assign tab[g] = 17'd65536;
    end else begin : g_mid
      assign tab[g] = tms_pkg::sine_from_x(XQ);
    end
  end

  always_ff @(posedge clk) begin
    data <= tab[addr];
  end

endmodule

/* sv/tms_mac.sv */
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered 32x32 product, 66-bit accumulator and Q15.16 round/saturate.
// ----------------------------------------------------------------------------
module tms_mac (
  input  logic               clk,
  input  logic               issue,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic               acc_en,
  input  logic               acc_clr,
  output logic signed [31:0] rnd
);

  logic signed [63:0] prod;
  logic signed [65:0] acc;

  always_ff @(posedge clk) begin
    if (issue) begin
      prod <= a * b;
    end
    if (acc_en) begin
      acc <= (acc_clr ? 66'sd0 : acc) + 66'(prod);
    end
  end

  assign rnd = tms_pkg::round_sat(acc);

endmodule

/* sv/transform_matrix_stack_unit.sv */
// ----------------------------------------------------------------------------
// Transform matrix stack unit
// Stack of 4x4 Q15.16 matrices with push, pop, identity, transform and read.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high until
// the command has finished its work. Results appear on the result ports for one
// cycle each, marked by valid; the receiver cannot stall them. A read gives four
// results (rows 0 to 3, last on row 3); every other command gives one.
// The matrix product runs 64 multiply-adds through the single shared multiplier
// and its two pipeline registers. Rotation first reads the sine and cosine from
// the table, then runs its setup on the same multiplier. A new request can be
// taken in the first cycle that busy is low. Reset empties the stack down to one
// identity matrix at once; no clearing pass is needed, since only the bottom
// entry is defined after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module transform_matrix_stack_unit #(
  parameter int STACK_DEPTH        = 32,
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] operand_x,
  input  logic signed [31:0] operand_y,
  input  logic signed [31:0] operand_z,
  input  logic [15:0]        angle,
  output logic               valid,
  output logic [1:0]         status,
  output logic [1:0]         row_index,
  output logic signed [31:0] coef_0,
  output logic signed [31:0] coef_1,
  output logic signed [31:0] coef_2,
  output logic signed [31:0] coef_3,
  output logic               last
);

  localparam int LW = $clog2(STACK_DEPTH);
  localparam int AW = LW + 4;
  localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);

  tms_pkg::state_t state, state_next;
  logic [6:0] cnt;
  logic [2:0] op;
  logic signed [31:0] ox, oy, oz;
  logic [15:0] ang;
  logic [LW-1:0] lvl;
  logic v0;
  logic [1:0] st_status;
  logic signed [31:0] old [16];
  logic signed [31:0] m [16];
  logic signed [31:0] m_init [16];
  logic signed [31:0] tmp;
  logic [16:0] sv_q;
  logic signed [17:0] s_val, c_val;
  logic signed [18:0] cc_val;
  logic [4:0] rstep;
  logic [1:0] phase;
  logic p1_v, p1_clr, p1_wr, p2_wr;
  logic [3:0] p1_idx, p2_idx;

  logic accept;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic signed [31:0] mem_wdata, mem_rdata;
  logic [IW-1:0] rom_addr, sidx;
  logic [16:0] rom_data;
  logic [14+IW-1:0] ri;
  logic issue;
  logic signed [31:0] mac_a, mac_b, mac_rnd;
  tms_pkg::rot_step_t step;
  logic [3:0] m_idx, old_idx, w_idx;
  logic signed [31:0] m_rd, bval, bsel, add_res, load_val;
  logic rot_wr;
  logic signed [31:0] rot_val;
  logic signed [17:0] sv18, cv18;

  assign busy   = (state != tms_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign step   = tms_pkg::rot_step(rstep);

  // Multiply order within the matrix product: row, column, inner index.
  assign old_idx = {cnt[5:4], cnt[1:0]};
  assign m_idx   = (state == tms_pkg::ST_ROT) ? step.dst[3:0] : {cnt[1:0], cnt[3:2]};
  assign m_rd    = m[m_idx];

  tms_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH * 16)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tms_sine_rom #(.ENTRIES(SINE_TABLE_ENTRIES)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  tms_mac u_mac (
    .clk     (clk),
    .issue   (issue),
    .a       (mac_a),
    .b       (mac_b),
    .acc_en  (p1_v),
    .acc_clr (p1_clr),
    .rnd     (mac_rnd)
  );

  function automatic logic signed [31:0] src(input logic [4:0] sel,
                                             input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic signed [31:0] z,
                                             input logic signed [17:0] s,
                                             input logic signed [17:0] c,
                                             input logic signed [18:0] cc,
                                             input logic signed [31:0] t);
    logic signed [31:0] v;
    priority case (sel)
      tms_pkg::SEL_X:   v = x;
      tms_pkg::SEL_Y:   v = y;
      tms_pkg::SEL_Z:   v = z;
      tms_pkg::SEL_S:   v = {{14{s[17]}}, s};
      tms_pkg::SEL_C:   v = {{14{c[17]}}, c};
      tms_pkg::SEL_CC:  v = {{13{cc[18]}}, cc};
      tms_pkg::SEL_TMP: v = t;
      default:          v = '0;
    endcase
    return v;
  endfunction

  // Sine table index from the angle within its quadrant.
  assign ri   = (14+IW)'(ang[13:0]) * (14+IW)'(SINE_TABLE_ENTRIES);
  assign sidx = IW'(ri >> 14);
  assign rom_addr = (cnt == 7'd0) ? sidx : IW'(SINE_TABLE_ENTRIES) - sidx;

  assign sv18 = $signed({1'b0, sv_q});
  assign cv18 = $signed({1'b0, rom_data});

  // Rotation setup arithmetic.
  assign bsel    = src(step.b, ox, oy, oz, s_val, c_val, cc_val, tmp);
  assign bval    = step.neg ? 32'(-bsel) : bsel;
  assign add_res = tms_pkg::sat32(66'(m_rd) + 66'(bval));
  assign rot_wr  = (state == tms_pkg::ST_ROT) &&
                   (((step.op == tms_pkg::STEP_ADD) && (phase == 2'd0)) ||
                    ((step.op == tms_pkg::STEP_MUL) && (phase == 2'd2)));
  assign rot_val = (step.op == tms_pkg::STEP_ADD) ? add_res : mac_rnd;

  // The bottom matrix reads as identity until it is first written.
  assign w_idx    = cnt[3:0] - 4'd1;
  assign load_val = ((lvl == '0) && !v0) ?
                    (tms_pkg::is_diag(w_idx) ? tms_pkg::ONE_Q16 : 32'sd0) : mem_rdata;

  // Right-hand matrix as loaded when a request is taken.
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      m_init[k] = tms_pkg::is_diag(4'(k)) ? tms_pkg::ONE_Q16 : 32'sd0;
    end
    if (opcode == tms_pkg::OP_TRANSLATE) begin
      m_init[3]  = operand_x;
      m_init[7]  = operand_y;
      m_init[11] = operand_z;
    end else if (opcode == tms_pkg::OP_SCALE) begin
      m_init[0]  = operand_x;
      m_init[5]  = operand_y;
      m_init[10] = operand_z;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tms_pkg::ST_IDLE: begin
        if (start) begin
          priority case (opcode)
            tms_pkg::OP_IDENTITY: state_next = tms_pkg::ST_FILL;
            tms_pkg::OP_PUSH:
              state_next = (lvl == LW'(STACK_DEPTH - 1)) ? tms_pkg::ST_FINISH
                                                         : tms_pkg::ST_LOAD;
            tms_pkg::OP_TRANSLATE: state_next = tms_pkg::ST_LOAD;
            tms_pkg::OP_SCALE:     state_next = tms_pkg::ST_LOAD;
            tms_pkg::OP_ROTATE:    state_next = tms_pkg::ST_SINE;
            tms_pkg::OP_READ:      state_next = tms_pkg::ST_LOAD;
            default:               state_next = tms_pkg::ST_FINISH;
          endcase
        end
      end
      tms_pkg::ST_LOAD: begin
        if (cnt == 7'd16) begin
          if (op == tms_pkg::OP_PUSH) state_next = tms_pkg::ST_COPY;
          else if (op == tms_pkg::OP_READ) state_next = tms_pkg::ST_EMIT;
          else state_next = tms_pkg::ST_MAC;
        end
      end
      tms_pkg::ST_SINE:   if (cnt == 7'd2) state_next = tms_pkg::ST_ROT;
      tms_pkg::ST_ROT:
        if (rot_wr && (rstep == tms_pkg::ROT_LAST_STEP)) state_next = tms_pkg::ST_LOAD;
      tms_pkg::ST_MAC:    if (cnt == 7'd65) state_next = tms_pkg::ST_FINISH;
      tms_pkg::ST_COPY:   if (cnt == 7'd15) state_next = tms_pkg::ST_FINISH;
      tms_pkg::ST_FILL:   if (cnt == 7'd15) state_next = tms_pkg::ST_FINISH;
      tms_pkg::ST_EMIT:   if (cnt == 7'd3) state_next = tms_pkg::ST_IDLE;
      tms_pkg::ST_FINISH: state_next = tms_pkg::ST_IDLE;
      default:            state_next = tms_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {lvl, cnt[3:0]};
    mem_wdata = '0;
    mem_raddr = {lvl, cnt[3:0]};
    issue     = 1'b0;
    mac_a     = old[old_idx];
    mac_b     = m_rd;
    unique case (state)
      tms_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = tms_pkg::is_diag(cnt[3:0]) ? tms_pkg::ONE_Q16 : 32'sd0;
      end
      tms_pkg::ST_COPY: begin
        mem_we    = 1'b1;
        mem_waddr = {lvl + LW'(1), cnt[3:0]};
        mem_wdata = old[0];
      end
      tms_pkg::ST_MAC: begin
        issue     = (cnt < 7'd64);
        mem_we    = p2_wr;
        mem_waddr = {lvl, p2_idx};
        mem_wdata = mac_rnd;
      end
      tms_pkg::ST_ROT: begin
        issue = (step.op == tms_pkg::STEP_MUL) && (phase == 2'd0);
        mac_a = src(step.a, ox, oy, oz, s_val, c_val, cc_val, tmp);
        mac_b = bsel;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tms_pkg::ST_IDLE;
      cnt    <= '0;
      lvl    <= '0;
      v0     <= 1'b0;
      p1_v   <= 1'b0;
      p1_wr  <= 1'b0;
      p2_wr  <= 1'b0;
      rstep  <= '0;
      phase  <= '0;
      valid  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 7'd0 : cnt + 7'd1;
      p1_v  <= issue;
      p1_wr <= issue && (state == tms_pkg::ST_MAC) && (cnt[1:0] == 2'd3);
      p2_wr <= p1_wr;
      valid <= (state == tms_pkg::ST_EMIT) || (state == tms_pkg::ST_FINISH);
      if (mem_we && (mem_waddr[AW-1:4] == '0)) begin
        v0 <= 1'b1;
      end
      if (accept) begin
        rstep <= '0;
        phase <= '0;
        if ((opcode == tms_pkg::OP_POP) && (lvl != '0)) begin
          lvl <= lvl - LW'(1);
        end
      end else if (rot_wr) begin
        rstep <= rstep + 5'd1;
        phase <= '0;
      end else if (state == tms_pkg::ST_ROT) begin
        phase <= phase + 2'd1;
      end
      if ((state == tms_pkg::ST_COPY) && (cnt == 7'd15)) begin
        lvl <= lvl + LW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    p1_clr <= (state != tms_pkg::ST_MAC) || (cnt[1:0] == 2'd0);
    p1_idx <= cnt[5:2];
    p2_idx <= p1_idx;
    if (accept) begin
      op  <= opcode;
      ox  <= operand_x;
      oy  <= operand_y;
      oz  <= operand_z;
      ang <= angle;
      if ((opcode == tms_pkg::OP_PUSH) && (lvl == LW'(STACK_DEPTH - 1))) begin
        st_status <= tms_pkg::STATUS_OVERFLOW;
      end else if ((opcode == tms_pkg::OP_POP) && (lvl == '0)) begin
        st_status <= tms_pkg::STATUS_UNDERFLOW;
      end else begin
        st_status <= tms_pkg::STATUS_OK;
      end
      for (int k = 0; k < 16; k++) begin
        m[k] <= m_init[k];
      end
    end else if (rot_wr) begin
      if (step.dst == tms_pkg::SEL_TMP) begin
        tmp <= rot_val;
      end else begin
        m[step.dst[3:0]] <= rot_val;
      end
      if (step.dup_en) begin
        m[step.dup] <= rot_val;
      end
    end

    if (state == tms_pkg::ST_SINE) begin
      if (cnt == 7'd1) begin
        sv_q <= rom_data;
      end
      if (cnt == 7'd2) begin
        unique case (ang[15:14])
          2'd0: begin s_val <= sv18;  c_val <= cv18;  end
          2'd1: begin s_val <= cv18;  c_val <= -sv18; end
          2'd2: begin s_val <= -sv18; c_val <= -cv18; end
          default: begin s_val <= -cv18; c_val <= sv18; end
        endcase
        unique case (ang[15:14])
          2'd0:    cc_val <= 19'sd65536 - 19'(cv18);
          2'd1:    cc_val <= 19'sd65536 + 19'(sv18);
          2'd2:    cc_val <= 19'sd65536 + 19'(cv18);
          default: cc_val <= 19'sd65536 - 19'(sv18);
        endcase
      end
    end

    if ((state == tms_pkg::ST_LOAD) && (cnt != 7'd0)) begin
      for (int k = 0; k < 15; k++) begin
        old[k] <= old[k+1];
      end
      old[15] <= load_val;
    end else if (state == tms_pkg::ST_COPY) begin
      for (int k = 0; k < 15; k++) begin
        old[k] <= old[k+1];
      end
    end else if (state == tms_pkg::ST_EMIT) begin
      for (int k = 0; k < 12; k++) begin
        old[k] <= old[k+4];
      end
    end

    if (state == tms_pkg::ST_EMIT) begin
      status    <= tms_pkg::STATUS_OK;
      row_index <= cnt[1:0];
      coef_0    <= old[0];
      coef_1    <= old[1];
      coef_2    <= old[2];
      coef_3    <= old[3];
      last      <= (cnt == 7'd3);
    end else begin
      status    <= st_status;
      row_index <= 2'd0;
      coef_0    <= '0;
      coef_1    <= '0;
      coef_2    <= '0;
      coef_3    <= '0;
      last      <= 1'b1;
    end
  end

  `ASSERT_CLK(a_rows_consecutive, clk, rst, valid && !last |=> valid, "read rows broken up")
  `ASSERT_CLK(a_accept_busy, clk, rst, start && !busy |=> busy, "request not taken")
  `ASSERT_NEVER(a_error_single, clk, rst, valid && (status != tms_pkg::STATUS_OK) && (!last || (row_index != 2'd0)), "error result not single")

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Transform matrix stack testbench
// Drives stack, transform, read and unused-code requests, predicts every result from a
// private copy of the matrix stack and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH = 32;
  localparam int SINE_N = 256;
  localparam int MAX_CYCLES = 400000;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        ang;
  } request_t;

  typedef struct {
    logic [1:0]         st;
    logic [1:0]         row;
    logic signed [31:0] c [4];
    logic               lst;
  } row_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] opcode = '0;
  logic signed [31:0] operand_x = '0, operand_y = '0, operand_z = '0;
  logic [15:0] angle = '0;
  logic busy, valid, last;
  logic [1:0] status, row_index;
  logic signed [31:0] coef_0, coef_1, coef_2, coef_3;

  transform_matrix_stack_unit dut (.*);

  always #1 clk = ~clk;

  request_t    pending_reqs [$];
  row_result_t expected_rows [$];
  int errors = 0;
  int sender_idle_pct = 0;
  bit stim_done = 0;
  bit taken = 0;
  int cycles = 0;

  // Shadow stack of matrices.
  logic signed [31:0] stack_mem [DEPTH][16];
  int unsigned level = 0;

  function automatic logic signed [31:0] sat_to32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return sat_to32((p + 128'sd32768) >>> 16);
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat_to32(128'(a) + 128'(b));
  endfunction

  function automatic logic signed [31:0] sine_lut(input int unsigned i);
    logic [63:0] x, t;
    logic signed [127:0] acc;
    if (i == 0) return 0;
    if (i >= SINE_N) return tms_pkg::ONE_Q16;
    x = 64'(i) * tms_pkg::HALF_PI_Q30 / SINE_N;
    t = x;
    acc = 128'(x);
    for (int n = 1; n <= 6; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - 128'(t);
      else acc = acc + 128'(t);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 8192) / 16384;
    if (acc > 65536) acc = 65536;
    return acc[31:0];
  endfunction

  task automatic apply_right(input logic signed [31:0] m [16]);
    logic signed [31:0] old [16];
    logic signed [127:0] acc;
    old = stack_mem[level];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc = acc + 128'(old[r * 4 + k]) * 128'(m[k * 4 + c]);
        // Rounding the exact sum matches the hardware, which accumulates full products first.
        stack_mem[level][r * 4 + c] = sat_to32((acc + 128'sd32768) >>> 16);
      end
  endtask

  function automatic void load_identity(output logic signed [31:0] m [16]);
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? tms_pkg::ONE_Q16 : 0;
  endfunction

  task automatic predict_request(input request_t q);
    logic signed [31:0] m [16];
    logic signed [31:0] s, c, cc, sv, cv;
    row_result_t res;
    int unsigned i;
    res.st = tms_pkg::STATUS_OK; res.row = 0; res.lst = 1;
    for (int j = 0; j < 4; j++) res.c[j] = 0;
    case (q.op)
      tms_pkg::OP_READ: begin
        for (int r = 0; r < 4; r++) begin
          res.row = r[1:0];
          for (int j = 0; j < 4; j++) res.c[j] = stack_mem[level][r * 4 + j];
          res.lst = (r == 3);
          expected_rows.insert(expected_rows.size(), res);
        end
        return;
      end
      tms_pkg::OP_IDENTITY: begin
        load_identity(m);
        stack_mem[level] = m;
      end
      tms_pkg::OP_PUSH: begin
        if (level >= DEPTH - 1) res.st = tms_pkg::STATUS_OVERFLOW;
        else begin
          stack_mem[level + 1] = stack_mem[level];
          level++;
        end
      end
      tms_pkg::OP_POP: begin
        if (level == 0) res.st = tms_pkg::STATUS_UNDERFLOW;
        else level--;
      end
      tms_pkg::OP_TRANSLATE: begin
        load_identity(m);
        m[3] = q.x; m[7] = q.y; m[11] = q.z;
        apply_right(m);
      end
      tms_pkg::OP_SCALE: begin
        load_identity(m);
        m[0] = q.x; m[5] = q.y; m[10] = q.z;
        apply_right(m);
      end
      tms_pkg::OP_ROTATE: begin
        i = int'(q.ang[13:0]) * SINE_N / 16384;
        sv = sine_lut(i);
        cv = sine_lut(SINE_N - i);
        case (q.ang[15:14])
          2'd0: begin s = sv;  c = cv;  end
          2'd1: begin s = cv;  c = -sv; end
          2'd2: begin s = -sv; c = -cv; end
          default: begin s = -cv; c = sv; end
        endcase
        cc = tms_pkg::ONE_Q16 - c;
        m[0]  = fx_add(fx_mul(fx_mul(q.x, q.x), cc), c);
        m[1]  = fx_add(fx_mul(fx_mul(q.x, q.y), cc), -fx_mul(q.z, s));
        m[2]  = fx_add(fx_mul(fx_mul(q.x, q.z), cc), fx_mul(q.y, s));
        m[3]  = 0;
        m[4]  = fx_add(fx_mul(fx_mul(q.y, q.x), cc), fx_mul(q.z, s));
        m[5]  = fx_add(fx_mul(fx_mul(q.y, q.y), cc), c);
        m[6]  = fx_add(fx_mul(fx_mul(q.y, q.z), cc), -fx_mul(q.x, s));
        m[7]  = 0;
        m[8]  = fx_add(fx_mul(fx_mul(q.z, q.x), cc), -fx_mul(q.y, s));
        m[9]  = fx_add(fx_mul(fx_mul(q.z, q.y), cc), fx_mul(q.x, s));
        m[10] = fx_add(fx_mul(fx_mul(q.z, q.z), cc), c);
        m[11] = 0; m[12] = 0; m[13] = 0; m[14] = 0; m[15] = tms_pkg::ONE_Q16;
        apply_right(m);
      end
      default: ;
    endcase
    expected_rows.insert(expected_rows.size(), res);
  endtask

  // A request is taken on the rising edge where start is high and busy low.
  always @(posedge clk) taken <= !rst && start && !busy;

  // Driver: the request just taken is predicted, then the next one is offered.
  always @(negedge clk) begin
    if (!rst) begin
      if (taken) begin
        predict_request(pending_reqs.pop_front());
      end
      if ((!start || taken) && pending_reqs.size() > 0
          && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        opcode <= pending_reqs[0].op; operand_x <= pending_reqs[0].x;
        operand_y <= pending_reqs[0].y; operand_z <= pending_reqs[0].z;
        angle <= pending_reqs[0].ang;
      end else if (taken) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    row_result_t e;
    logic signed [31:0] got [4];
    bit bad;
    cycles <= cycles + 1;
    if (!rst && valid) begin
      got[0] = coef_0; got[1] = coef_1; got[2] = coef_2; got[3] = coef_3;
      if (expected_rows.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result row %0d status %0d", row_index, status);
      end else begin
        e = expected_rows.pop_front();
        bad = (e.st !== status) || (e.row !== row_index) || (e.lst !== last);
        for (int j = 0; j < 4; j++) bad = bad || (e.c[j] !== got[j]);
        if (bad) begin
          errors <= errors + 1;
          if (errors < 10)
            $display({"mismatch: exp st %0d row %0d %h %h %h %h last %0d, ",
                      "got st %0d row %0d %h %h %h %h last %0d"},
                     e.st, e.row, e.c[0], e.c[1], e.c[2], e.c[3], e.lst,
                     status, row_index, got[0], got[1], got[2], got[3], last);
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(131072)) - 65536;
      2: return $signed($urandom_range(1024)) - 512;
      3: return tms_pkg::ONE_Q16;
      default: return $signed($urandom_range(6553600)) - 3276800;
    endcase
  endfunction

  task automatic add_req(input logic [2:0] op, input logic signed [31:0] x,
                         input logic signed [31:0] y, input logic signed [31:0] z,
                         input logic [15:0] a);
    request_t q;
    q.op = op; q.x = x; q.y = y; q.z = z; q.ang = a;
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  task automatic add_random_req();
    int pick;
    logic [2:0] op;
    pick = $urandom_range(99);
    if (pick < 12) op = tms_pkg::OP_PUSH;
    else if (pick < 22) op = tms_pkg::OP_POP;
    else if (pick < 27) op = tms_pkg::OP_IDENTITY;
    else if (pick < 42) op = tms_pkg::OP_TRANSLATE;
    else if (pick < 55) op = tms_pkg::OP_SCALE;
    else if (pick < 72) op = tms_pkg::OP_ROTATE;
    else if (pick < 97) op = tms_pkg::OP_READ;
    else op = OP_UNUSED;
    add_req(op, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
  endtask

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || start || busy || expected_rows.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int idle_sched [4] = '{0, 81, 0, 22};
    // The stack starts with one identity matrix.
    load_identity(stack_mem[0]);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, all opcodes, underflow, overflow, unused code.
    add_req(tms_pkg::OP_READ, 0, 0, 0, 0);
    add_req(tms_pkg::OP_POP, 0, 0, 0, 0);
    add_req(OP_UNUSED, 32'sh7FFFFFFF, 32'sh80000000, -1, 16'hFFFF);
    add_req(tms_pkg::OP_TRANSLATE, tms_pkg::ONE_Q16 * 3, -tms_pkg::ONE_Q16,
            32'sh7FFFFFFF, 0);
    add_req(tms_pkg::OP_READ, 0, 0, 0, 0);
    add_req(tms_pkg::OP_SCALE, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
    add_req(tms_pkg::OP_READ, 0, 0, 0, 0);
    add_req(tms_pkg::OP_IDENTITY, 0, 0, 0, 0);
    add_req(tms_pkg::OP_ROTATE, 0, 0, tms_pkg::ONE_Q16, 16'h2000);
    add_req(tms_pkg::OP_ROTATE, tms_pkg::ONE_Q16, 0, 0, 16'h4000);
    add_req(tms_pkg::OP_ROTATE, 0, tms_pkg::ONE_Q16, 0, 16'hC000);
    add_req(tms_pkg::OP_ROTATE, 32'sh7FFFFFFF, 32'sh80000000, -1, 16'hFFFF);
    add_req(tms_pkg::OP_READ, 0, 0, 0, 0);
    add_req(tms_pkg::OP_ROTATE, tms_pkg::ONE_Q16 * 2, tms_pkg::ONE_Q16 * 2,
            tms_pkg::ONE_Q16 * 2, 16'h8000);
    add_req(tms_pkg::OP_READ, 0, 0, 0, 0);
    for (int k = 0; k < DEPTH; k++) add_req(tms_pkg::OP_PUSH, 0, 0, 0, 0);
    add_req(tms_pkg::OP_READ, 0, 0, 0, 0);
    for (int k = 0; k < DEPTH; k++) add_req(tms_pkg::OP_POP, 0, 0, 0, 0);
    add_req(tms_pkg::OP_READ, 0, 0, 0, 0);
    // Random phases, with sender idling set per phase from a schedule.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_sched[ph];
      for (int k = 0; k < 50; k++) add_random_req();
      wait_drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done || cycles >= MAX_CYCLES);
    if (cycles >= MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      repeat (200) @(posedge clk);
      if (errors == 0 && expected_rows.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
